>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: invariant");

// antecedent in this cycle implies consequent in the same cycle or a sequence
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("assertion failed: implication");

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_IMPLIES_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_IMPLIES_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/isr_pkg.sv
// ----------------------------------------------------------------------------
// isr_pkg
// shared widths, register indexes and reset values of the ising ring updater
// ----------------------------------------------------------------------------
`default_nettype none

package isr_pkg;

  // ring geometry
  localparam int MAX_SITES = 1024;
  localparam int SITE_W    = $clog2(MAX_SITES);
  localparam int NUM_W     = SITE_W + 1;

  // spin memory organized as rows of bits
  localparam int ROW_BITS  = 8;
  localparam int BIT_W     = $clog2(ROW_BITS);
  localparam int ROWS      = MAX_SITES / ROW_BITS;
  localparam int ROW_W     = SITE_W - BIT_W;

  // probabilities
  localparam int PROB_BITS = 16;
  localparam int TH_BITS   = PROB_BITS + 1;
  localparam int TAB_W     = 3 * TH_BITS;

  // running totals
  localparam int TOT_W     = 12;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TAB_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SITES  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_METRO_UP   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_METRO_DOWN = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_GIBBS      = CFG_IDX_W'(4);

  // update modes and item functions
  localparam logic MODE_METRO = 1'b0;
  localparam logic MODE_GIBBS = 1'b1;
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  // reset values
  localparam logic [NUM_W-1:0] NUM_MIN   = NUM_W'(2);
  localparam logic [NUM_W-1:0] NUM_MAX   = NUM_W'(MAX_SITES);
  localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(MAX_SITES);
  localparam logic [TAB_W-1:0] METRO_RESET = TAB_W'(51'd1125908496842752);
  localparam logic [TAB_W-1:0] GIBBS_RESET = TAB_W'(51'd562954248421376);

endpackage

`default_nettype wire

>>> rtl/isr_if.sv
// ----------------------------------------------------------------------------
// isr_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface isr_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [isr_pkg::SITE_W-1:0]   site;
  logic                         proposed_spin;
  logic [isr_pkg::PROB_BITS-1:0] rand_u;

  modport source (output valid, func, site, proposed_spin, rand_u, input ready);
  modport sink   (input valid, func, site, proposed_spin, rand_u, output ready);
endinterface

interface isr_out_if;
  logic                             valid;
  logic                             ready;
  logic [isr_pkg::SITE_W-1:0]       out_site;
  logic                             new_spin;
  logic                             accepted;
  logic signed [isr_pkg::TOT_W-1:0] magnetization;
  logic signed [isr_pkg::TOT_W-1:0] bond_sum;

  modport source (output valid, out_site, new_spin, accepted, magnetization, bond_sum,
                  input ready);
  modport sink   (input valid, out_site, new_spin, accepted, magnetization, bond_sum,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/isr_ram.sv
// ----------------------------------------------------------------------------
// isr_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module isr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/ising_ring_spin_update.sv
// ising_ring_spin_update: one item in flight, three reads of the spin memory per item
// a new item is taken only in idle, after the left, right and own-row reads of the
//   single read port of the spin memory and the write-back of the item before it;
//   the result is registered at write-back, which stalls while a result is untaken
// reset: config to defaults, ring all up, totals = num_sites; spin rows carry valid
//   bits so reset and num_sites writes take effect at once, with no clearing pass
// ----------------------------------------------------------------------------
// ising_ring_spin_update
// metropolis / gibbs single-site update of a periodic 1-d ising ring
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ising_ring_spin_update (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [isr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [isr_pkg::CFG_DATA_W-1:0]   cfg_data,
  isr_in_if.sink                                in_item,
  isr_out_if.source                             out_item
);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an item
  localparam logic [2:0] S_RD_L = 3'd1;  // read row of left neighbour
  localparam logic [2:0] S_RD_R = 3'd2;  // read row of right neighbour
  localparam logic [2:0] S_RD_S = 3'd3;  // read row of the site itself
  localparam logic [2:0] S_WB   = 3'd4;  // decide, write back, load result

  // configuration registers
  logic                              mode;
  logic [isr_pkg::NUM_W-1:0]         num_sites;
  logic [isr_pkg::TAB_W-1:0]         metro_up;
  logic [isr_pkg::TAB_W-1:0]         metro_down;
  logic [isr_pkg::TAB_W-1:0]         gibbs;
  logic [isr_pkg::NUM_W-1:0]         num_clamped;

  // running totals
  logic signed [isr_pkg::TOT_W-1:0]  magnet_total;
  logic signed [isr_pkg::TOT_W-1:0]  bond_total;
  logic signed [isr_pkg::TOT_W-1:0]  magnet_next;
  logic signed [isr_pkg::TOT_W-1:0]  bond_next;
  logic signed [isr_pkg::TOT_W-1:0]  bond_delta;

  // sequencer and item registers
  logic [2:0]                        state;
  logic [2:0]                        state_next;
  logic                              item_func;
  logic [isr_pkg::SITE_W-1:0]        item_site;
  logic                              item_prop;
  logic [isr_pkg::PROB_BITS-1:0]     item_rand;
  logic                              item_ok;
  logic [isr_pkg::SITE_W-1:0]        left_site;
  logic [isr_pkg::SITE_W-1:0]        right_site;
  logic                              left_spin;
  logic                              right_spin;

  // neighbour addresses of the incoming item
  logic [isr_pkg::SITE_W-1:0]        in_left;
  logic [isr_pkg::SITE_W-1:0]        in_right;
  logic [isr_pkg::NUM_W-1:0]         in_site_inc;

  // spin memory
  logic [isr_pkg::ROWS-1:0]          row_valid;
  logic                              rd_valid;
  logic [isr_pkg::ROW_W-1:0]         raddr;
  logic [isr_pkg::ROW_BITS-1:0]      rdata;
  logic [isr_pkg::ROW_BITS-1:0]      row_word;
  logic [isr_pkg::ROW_BITS-1:0]      wdata;
  logic                              ram_we;

  // decision
  logic [1:0]                        nidx;
  logic                              cur_spin;
  logic                              nxt_spin;
  logic                              acc_c;
  logic [isr_pkg::TAB_W-1:0]         tab_sel;
  logic [isr_pkg::TH_BITS-1:0]       th;
  logic                              below;
  logic                              wb_fire;
  logic                              in_fire;
  logic                              change;

  // result register
  logic                              out_valid;
  logic [isr_pkg::SITE_W-1:0]        out_site_q;
  logic                              out_spin_q;
  logic                              out_acc_q;
  logic signed [isr_pkg::TOT_W-1:0]  out_mag_q;
  logic signed [isr_pkg::TOT_W-1:0]  out_bond_q;

  isr_ram #(
    .WIDTH (isr_pkg::ROW_BITS),
    .DEPTH (isr_pkg::ROWS)
  ) u_spin_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item_site[isr_pkg::SITE_W-1:isr_pkg::BIT_W]),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------

  // ring length clamped to 2 .. MAX_SITES
  always_comb begin
    num_clamped = cfg_data[isr_pkg::NUM_W-1:0];
    priority if (num_clamped < isr_pkg::NUM_MIN) begin
      num_clamped = isr_pkg::NUM_MIN;
    end else if (num_clamped > isr_pkg::NUM_MAX) begin
      num_clamped = isr_pkg::NUM_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= isr_pkg::MODE_METRO;
      num_sites  <= isr_pkg::NUM_RESET;
      metro_up   <= isr_pkg::METRO_RESET;
      metro_down <= isr_pkg::METRO_RESET;
      gibbs      <= isr_pkg::GIBBS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        isr_pkg::CFG_MODE:       mode       <= cfg_data[0];
        isr_pkg::CFG_NUM_SITES:  num_sites  <= num_clamped;
        isr_pkg::CFG_METRO_UP:   metro_up   <= cfg_data;
        isr_pkg::CFG_METRO_DOWN: metro_down <= cfg_data;
        isr_pkg::CFG_GIBBS:      gibbs      <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: accept, three row reads, write-back
  // ---------------------------------------------------------------------------

  assign in_item.ready = (state == S_IDLE);
  assign in_fire       = in_item.valid && in_item.ready;
  assign wb_fire       = (state == S_WB) && (!out_valid || out_item.ready);

  // ring neighbours with wrap-around at both ends
  assign in_site_inc = {1'b0, in_item.site} + isr_pkg::NUM_W'(1);
  assign in_left  = (in_item.site == '0) ? isr_pkg::SITE_W'(num_sites - isr_pkg::NUM_W'(1))
                                         : in_item.site - isr_pkg::SITE_W'(1);
  assign in_right = (in_site_inc >= num_sites) ? '0 : in_site_inc[isr_pkg::SITE_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_fire) state_next = S_RD_L;
      S_RD_L:  state_next = S_RD_R;
      S_RD_R:  state_next = S_RD_S;
      S_RD_S:  state_next = S_WB;
      S_WB:    if (wb_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_func  <= in_item.func;
      item_site  <= in_item.site;
      item_prop  <= in_item.proposed_spin;
      item_rand  <= in_item.rand_u;
      item_ok    <= ({1'b0, in_item.site} < num_sites);
      left_site  <= in_left;
      right_site <= in_right;
    end
    // read data arrives in the cycle after the address
    if (state == S_RD_R) begin
      left_spin <= row_word[left_site[isr_pkg::BIT_W-1:0]];
    end
    if (state == S_RD_S) begin
      right_spin <= row_word[right_site[isr_pkg::BIT_W-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // spin memory access; a row never written since reset or resize reads all up
  // ---------------------------------------------------------------------------

  always_comb begin
    unique case (state)
      S_RD_L:  raddr = left_site[isr_pkg::SITE_W-1:isr_pkg::BIT_W];
      S_RD_R:  raddr = right_site[isr_pkg::SITE_W-1:isr_pkg::BIT_W];
      default: raddr = item_site[isr_pkg::SITE_W-1:isr_pkg::BIT_W];
    endcase
  end

  assign row_word = rd_valid ? rdata : '1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= row_valid[raddr];
      if (cfg_we && (cfg_index == isr_pkg::CFG_NUM_SITES)) begin
        row_valid <= '0;
      end else if (ram_we) begin
        row_valid[item_site[isr_pkg::SITE_W-1:isr_pkg::BIT_W]] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // acceptance decision in the write-back cycle
  // ---------------------------------------------------------------------------

  // neighbour sum -2, 0, +2 maps to table field 0, 1, 2
  assign nidx     = {1'b0, left_spin} + {1'b0, right_spin};
  assign cur_spin = row_word[item_site[isr_pkg::BIT_W-1:0]];

  always_comb begin
    priority if (mode == isr_pkg::MODE_GIBBS) begin
      tab_sel = gibbs;
    end else if (cur_spin) begin
      tab_sel = metro_up;
    end else begin
      tab_sel = metro_down;
    end
  end

  always_comb begin
    unique case (nidx)
      2'd0:    th = tab_sel[0*isr_pkg::TH_BITS +: isr_pkg::TH_BITS];
      2'd1:    th = tab_sel[1*isr_pkg::TH_BITS +: isr_pkg::TH_BITS];
      2'd2:    th = tab_sel[2*isr_pkg::TH_BITS +: isr_pkg::TH_BITS];
      default: th = '0;
    endcase
  end

  assign below = ({1'b0, item_rand} < th);

  always_comb begin
    nxt_spin = cur_spin;
    acc_c    = 1'b1;
    priority if (item_func == isr_pkg::FUNC_LOAD) begin
      nxt_spin = item_prop;
    end else if (mode == isr_pkg::MODE_GIBBS) begin
      nxt_spin = below;
    end else if (item_prop != cur_spin) begin
      // metropolis flip proposal
      acc_c    = below;
      nxt_spin = below ? item_prop : cur_spin;
    end
  end

  assign change = item_ok && (nxt_spin != cur_spin);
  assign ram_we = wb_fire && change;

  always_comb begin
    wdata = row_word;
    wdata[item_site[isr_pkg::BIT_W-1:0]] = nxt_spin;
  end

  // bond change is delta * nsum, i.e. +-4 or 0
  always_comb begin
    unique case (nidx)
      2'd0:    bond_delta = -isr_pkg::TOT_W'(4);
      2'd2:    bond_delta = isr_pkg::TOT_W'(4);
      default: bond_delta = '0;
    endcase
    if (!nxt_spin) begin
      bond_delta = -bond_delta;
    end
  end

  always_comb begin
    magnet_next = magnet_total;
    bond_next   = bond_total;
    if (change) begin
      magnet_next = nxt_spin ? magnet_total + isr_pkg::TOT_W'(2)
                             : magnet_total - isr_pkg::TOT_W'(2);
      bond_next   = bond_total + bond_delta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magnet_total <= isr_pkg::TOT_W'(isr_pkg::NUM_RESET);
      bond_total   <= isr_pkg::TOT_W'(isr_pkg::NUM_RESET);
    end else if (cfg_we && (cfg_index == isr_pkg::CFG_NUM_SITES)) begin
      magnet_total <= isr_pkg::TOT_W'(num_clamped);
      bond_total   <= isr_pkg::TOT_W'(num_clamped);
    end else if (wb_fire) begin
      magnet_total <= magnet_next;
      bond_total   <= bond_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb_fire) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_fire) begin
      out_site_q <= item_site;
      out_spin_q <= item_ok && nxt_spin;
      out_acc_q  <= item_ok && acc_c;
      out_mag_q  <= magnet_next;
      out_bond_q <= bond_next;
    end
  end

  assign out_item.valid         = out_valid;
  assign out_item.out_site      = out_site_q;
  assign out_item.new_spin      = out_spin_q;
  assign out_item.accepted      = out_acc_q;
  assign out_item.magnetization = out_mag_q;
  assign out_item.bond_sum      = out_bond_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------

  // an accepted item reaches write-back after its three reads
  `ASSERT_IMPLIES(a_wb_timing, clk, rst, in_fire, ##4 (state == S_WB))

  // resizing the ring drops every stored row
  `ASSERT_IMPLIES_NEXT(a_resize_clears, clk, rst,
    cfg_we && (cfg_index == isr_pkg::CFG_NUM_SITES), row_valid == '0)

  // a sum of num_sites values of +-1 shares its parity with num_sites
  `ASSERT_ALWAYS(a_magnet_parity, clk, rst, magnet_total[0] == num_sites[0])

  // the count of broken bonds is even, so the bond sum matches num_sites mod 4
  `ASSERT_ALWAYS(a_bond_mod4, clk, rst, bond_total[1:0] == num_sites[1:0])

endmodule

`default_nettype wire
